/* hdl/eds_pkg.sv */
// ----------------------------------------------------------------------------
// eds_pkg
// shared types and constants for the encoder detent event source
// ----------------------------------------------------------------------------
package eds_pkg;

  // field widths
  localparam int CountW   = 16;
  localparam int TimeW    = 32;
  localparam int ResidueW = 18;
  localparam int AluW     = 19;
  localparam int SpdW     = 8;
  localparam int KindW    = 2;
  localparam int StepW    = 2;
  localparam int TurnCntW = 6;

  // stream packing
  localparam int InDataW  = 56;  // 16 + 1 + 32 = 49, padded to bytes
  localparam int OutDataW = 40;  // 2 + 32 = 34, padded to bytes

  // turn events allowed per sample
  localparam logic [TurnCntW-1:0] MaxTurnsPerSample = 6'd63;

  // configuration register indexes
  localparam logic [1:0] RegEncoderEnable   = 2'd0;
  localparam logic [1:0] RegStepsPerDetent  = 2'd1;
  localparam logic [1:0] RegDirectionInvert = 2'd2;

  localparam logic [SpdW-1:0] StepsPerDetentReset = 8'd4;

  // event kinds
  typedef enum logic [KindW-1:0] {
    KIND_TURN     = 2'd0,
    KIND_BTN_DOWN = 2'd1,
    KIND_BTN_UP   = 2'd2
  } event_kind_t;

  localparam logic signed [StepW-1:0] StepPos  = 2'sb01;
  localparam logic signed [StepW-1:0] StepNeg  = 2'sb11;
  localparam logic signed [StepW-1:0] StepNone = 2'sb00;

endpackage

/* hdl/encoder_detent_event_source.sv */
// ----------------------------------------------------------------------------
// encoder_detent_event_source
// turns quadrature counter samples and a button level into detent and
// button events, one event beat at a time
// ----------------------------------------------------------------------------
//
// channel  dir  handshake              payload
// in_      in   in_tvalid/in_tready    tdata: counter_value, button_pressed,
//                                      timestamp_ms
// out_     out  out_tvalid/out_tready  tdata: turn_step, event_time;
//                                      tuser: event_kind; tlast: last_event
// cfg_     in   cfg_wr_en              cfg_addr selects register, cfg_wdata
//
// sequence: after a beat is accepted, the counter change, the residue sum
//   and the first detent check follow in S_DELTA, S_SUM and S_CHK, all on
//   a single shared 19-bit adder; then S_LOOK sends the turn events one by
//   one and S_BTN closes the sample, carrying the button event if there is
//   one; with the encoder off a sample goes from S_IDLE straight to S_BTN
// the shared adder also does the detent subtract and compare, which sets
//   the one-event-per-cycle pace while the output does not stall
// reset: synchronous active low; registers go to encoder on, 4 steps per
//   detent, no inversion, zero count and residue, button up
// stalls: out_tready low holds the sequencer on the pending event; in_tready
//   is high only while the sequencer is idle
//
module encoder_detent_event_source (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration
  input  logic                         cfg_wr_en,
  input  logic [1:0]                   cfg_addr,
  input  logic [eds_pkg::SpdW-1:0]     cfg_wdata,
  // sample stream
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [eds_pkg::InDataW-1:0]  in_tdata,   // counter_value, button_pressed, timestamp_ms
  // event stream
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [eds_pkg::OutDataW-1:0] out_tdata,  // turn_step, event_time
  output logic [eds_pkg::KindW-1:0]    out_tuser,  // event_kind
  output logic                         out_tlast
);

  import eds_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DELTA,
    S_SUM,
    S_CHK,
    S_LOOK,
    S_BTN
  } state_t;

  state_t state_r;

  // configuration
  logic            enable_r;
  logic [SpdW-1:0] spd_r;
  logic            invert_r;

  // persistent state
  logic signed [CountW-1:0]   prev_r;
  logic signed [ResidueW-1:0] res_r;
  logic                       btn_was_r;

  // per-sample working registers
  logic signed [CountW-1:0]   cur_r;
  logic                       btn_r;
  logic [TimeW-1:0]           ts_r;
  logic signed [ResidueW-1:0] delta_r;
  logic [TurnCntW-1:0]        turns_r;
  logic                       step_pos_r;

  // output register
  logic                     out_valid_r;
  event_kind_t              out_kind_r;
  logic signed [StepW-1:0]  out_step_r;
  logic [TimeW-1:0]         out_time_r;
  logic                     out_last_r;

  // shared adder
  logic signed [AluW-1:0] op_a;
  logic signed [AluW-1:0] op_b;
  logic                   alu_sub;
  logic signed [AluW-1:0] alu_y;

  logic [SpdW-1:0]            spd_eff;
  logic                       qual;
  logic                       btn_chg;
  logic                       out_free;
  logic                       emit;
  logic signed [ResidueW-1:0] sum_sat;

  // zero steps per detent behaves as one
  assign spd_eff  = (spd_r == '0) ? {{(SpdW-1){1'b0}}, 1'b1} : spd_r;
  assign btn_chg  = (btn_r != btn_was_r);
  assign out_free = !out_valid_r || out_tready;
  // an event beat is loaded into the output register this cycle
  assign emit     = out_free && ((state_r == S_LOOK) || (state_r == S_BTN && btn_chg));

  // operand selection per sequencer step
  always_comb begin
    op_a    = {{(AluW-ResidueW){res_r[ResidueW-1]}}, res_r};
    op_b    = {{(AluW-SpdW){1'b0}}, spd_eff};
    alu_sub = !res_r[ResidueW-1];
    case (state_r)
      S_DELTA: begin
        // change = cur - prev, or prev - cur when inverted
        if (invert_r) begin
          op_a = {{(AluW-CountW){prev_r[CountW-1]}}, prev_r};
          op_b = {{(AluW-CountW){cur_r[CountW-1]}}, cur_r};
        end else begin
          op_a = {{(AluW-CountW){cur_r[CountW-1]}}, cur_r};
          op_b = {{(AluW-CountW){prev_r[CountW-1]}}, prev_r};
        end
        alu_sub = 1'b1;
      end
      S_SUM: begin
        op_b    = {{(AluW-ResidueW){delta_r[ResidueW-1]}}, delta_r};
        alu_sub = 1'b0;
      end
      default: ;
    endcase
  end

  assign alu_y = op_a + (alu_sub ? ~op_b : op_b) + {{(AluW-1){1'b0}}, alu_sub};

  // residue sum clamped to the residue width
  always_comb begin
    if (!alu_y[AluW-1] && alu_y[AluW-2]) begin
      sum_sat = {1'b0, {(ResidueW-1){1'b1}}};
    end else if (alu_y[AluW-1] && !alu_y[AluW-2]) begin
      sum_sat = {1'b1, {(ResidueW-1){1'b0}}};
    end else begin
      sum_sat = alu_y[ResidueW-1:0];
    end
  end

  // a whole detent remains and the per-sample turn cap is not yet reached:
  // positive residue minus spd stays non-negative, negative residue plus spd stays non-positive
  assign qual = (turns_r < MaxTurnsPerSample) &&
                (res_r[ResidueW-1] ? (alu_y[AluW-1] || (alu_y == '0))
                                   : !alu_y[AluW-1]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      enable_r    <= 1'b1;
      spd_r       <= StepsPerDetentReset;
      invert_r    <= 1'b0;
      prev_r      <= '0;
      res_r       <= '0;
      btn_was_r   <= 1'b0;
      turns_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_addr)
          RegEncoderEnable:   enable_r <= cfg_wdata[0];
          RegStepsPerDetent:  spd_r    <= cfg_wdata;
          RegDirectionInvert: invert_r <= cfg_wdata[0];
          default: ;
        endcase
      end

      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            cur_r   <= in_tdata[CountW-1:0];
            btn_r   <= in_tdata[CountW];
            ts_r    <= in_tdata[CountW+TimeW:CountW+1];
            turns_r <= '0;
            state_r <= enable_r ? S_DELTA : S_BTN;
          end
        end
        S_DELTA: begin
          delta_r <= alu_y[ResidueW-1:0];
          prev_r  <= cur_r;
          state_r <= S_SUM;
        end
        S_SUM: begin
          res_r   <= sum_sat;
          state_r <= S_CHK;
        end
        S_CHK: begin
          // commit the first turn, its beat goes out once the next is known
          if (qual) begin
            res_r      <= alu_y[ResidueW-1:0];
            turns_r    <= turns_r + 1'b1;
            step_pos_r <= !res_r[ResidueW-1];
            state_r    <= S_LOOK;
          end else begin
            state_r <= S_BTN;
          end
        end
        S_LOOK: begin
          if (out_free) begin
            out_kind_r  <= KIND_TURN;
            out_step_r  <= step_pos_r ? StepPos : StepNeg;
            out_time_r  <= ts_r;
            out_last_r  <= !qual && !btn_chg;
            if (qual) begin
              res_r   <= alu_y[ResidueW-1:0];
              turns_r <= turns_r + 1'b1;
            end else begin
              state_r <= S_BTN;
            end
          end
        end
        S_BTN: begin
          if (btn_chg) begin
            if (out_free) begin
              out_kind_r  <= btn_r ? KIND_BTN_DOWN : KIND_BTN_UP;
              out_step_r  <= StepNone;
              out_time_r  <= ts_r;
              out_last_r  <= 1'b1;
              btn_was_r   <= btn_r;
              state_r     <= S_IDLE;
            end
          end else begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OutDataW-StepW-TimeW){1'b0}}, out_time_r, out_step_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  // button events always close a sample
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r != KIND_TURN) |-> out_last_r)
    else $error("button event not flagged last");

  // turn step is nonzero exactly on turn events
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_kind_r == KIND_TURN) == (out_step_r != StepNone)))
    else $error("turn step does not match event kind");

  // an accepted sample keeps the input closed the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input reopened right after accept");

  // a pending turn has always been counted against the cap
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOOK) |-> (turns_r != '0))
    else $error("pending turn without turn count");

endmodule
